[rtl/core/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, codes and constants of the clock / timer / stopwatch block.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int OP_W     = 3;
  localparam int SET_W    = 7;
  localparam int LED_W    = 8;
  localparam int CLK_H_W  = 5;
  localparam int MS_W     = 6;
  localparam int CNT_H_W  = 7;
  localparam int TPS_W    = 12;
  localparam int BLK_W    = 9;
  localparam int MODE_W   = 2;
  localparam int LPOS_W   = 3;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [TPS_W-1:0]   TPS_RST      = 12'd4000;
  localparam logic [BLK_W-1:0]   BLINK_RST    = 9'd500;
  localparam logic [MS_W-1:0]    MS_MAX       = 6'd59;
  localparam logic [CLK_H_W-1:0] CLK_HOUR_MAX = 5'd23;
  localparam logic [CNT_H_W-1:0] CNT_HOUR_MAX = 7'd99;
  localparam logic [LED_W-1:0]   LED_ALL_ON   = 8'hff;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_LOAD_CLK  = 3'd1,
    OP_LOAD_CNT  = 3'd2,
    OP_CLEAR_CNT = 3'd3,
    OP_MENU_RST  = 3'd4,
    OP_CLK_RST   = 3'd5
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE      = 2'd0,
    MODE_CLOCK     = 2'd1,
    MODE_TIMER     = 2'd2,
    MODE_STOPWATCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_TPS   = 2'd1,
    REG_BLINK = 2'd2
  } reg_idx_e;

endpackage

[rtl/core/cts_in_if.sv]
// ----------------------------------------------------------------------------
// cts_in_if
// Request channel of the clock / timer / stopwatch block: op and set values.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic                      valid;
  logic                      ready;
  logic [cts_pkg::OP_W-1:0]  op;
  logic [cts_pkg::SET_W-1:0] set_hour;
  logic [cts_pkg::SET_W-1:0] set_minute;
  logic [cts_pkg::SET_W-1:0] set_second;

  modport source (output valid, op, set_hour, set_minute, set_second, input ready);
  modport sink   (input valid, op, set_hour, set_minute, set_second, output ready);
endinterface

[rtl/core/cts_out_if.sv]
// ----------------------------------------------------------------------------
// cts_out_if
// Result channel of the clock / timer / stopwatch block: LEDs, alert, times.
// ----------------------------------------------------------------------------
interface cts_out_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::LED_W-1:0]   led_pattern;
  logic                        alert;
  logic [cts_pkg::CLK_H_W-1:0] clock_hour;
  logic [cts_pkg::MS_W-1:0]    clock_minute;
  logic [cts_pkg::MS_W-1:0]    clock_second;
  logic [cts_pkg::CNT_H_W-1:0] count_hour;
  logic [cts_pkg::MS_W-1:0]    count_minute;
  logic [cts_pkg::MS_W-1:0]    count_second;

  modport source (output valid, led_pattern, alert, clock_hour, clock_minute, clock_second,
                  count_hour, count_minute, count_second, input ready);
  modport sink   (input valid, led_pattern, alert, clock_hour, clock_minute, clock_second,
                  count_hour, count_minute, count_second, output ready);
endinterface

[rtl/core/clock_timer_stopwatch_tick.sv]
// ----------------------------------------------------------------------------
// clock_timer_stopwatch_tick
// Time-of-day clock, countdown timer and stopwatch driven by tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests (op, set_hour, set_minute, set_second), valid/ready.
//   out_ch : one result per request: LED pattern, alert, clock and counter
//            values as they stand after that request.
//   cfg_*  : APB write/read of mode (0x0), ticks_per_second (0x4),
//            blink_ticks (0x8). Write only while no request is in flight.
// Timing:
//   A request is registered in the input stage on acceptance; its result is
//   registered when that stage advances. Throughput is one request per cycle
//   while out_ch takes each result; the state update loop sets that rate.
// Reset:
//   rst_n clears all counters, the LED state and both channel stages; config
//   returns to mode 0, 4000 ticks per second, 500 ticks per blink.
// Stall:
//   While a result waits on out_ch, one more request is still taken into the
//   input stage; then in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module clock_timer_stopwatch_tick (
  input  logic                         clk,
  input  logic                         rst_n,
  cts_in_if.sink                       in_ch,
  cts_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cts_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [cts_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [cts_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  // config
  logic [cts_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [cts_pkg::TPS_W-1:0]   tps_r;
  logic [cts_pkg::BLK_W-1:0]   blink_ticks_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  // input stage
  logic                        in_vld_r;
  logic [cts_pkg::OP_W-1:0]    in_op_r;
  logic [cts_pkg::SET_W-1:0]   in_hour_r, in_min_r, in_sec_r;
  logic                        out_vld_r;
  logic                        adv;

  // state
  logic                        clk_run_r, clk_run_nxt;
  logic [cts_pkg::TPS_W-1:0]   clk_tick_r, clk_tick_nxt;
  logic [cts_pkg::CLK_H_W-1:0] clk_hour_r, clk_hour_nxt;
  logic [cts_pkg::MS_W-1:0]    clk_min_r, clk_min_nxt;
  logic [cts_pkg::MS_W-1:0]    clk_sec_r, clk_sec_nxt;
  logic [cts_pkg::TPS_W-1:0]   cnt_tick_r, cnt_tick_nxt;
  logic [cts_pkg::CNT_H_W-1:0] cnt_hour_r, cnt_hour_nxt;
  logic [cts_pkg::MS_W-1:0]    cnt_min_r, cnt_min_nxt;
  logic [cts_pkg::MS_W-1:0]    cnt_sec_r, cnt_sec_nxt;
  logic [cts_pkg::LPOS_W-1:0]  led_pos_r, led_pos_nxt;
  logic                        alert_r, alert_nxt;
  logic [cts_pkg::BLK_W-1:0]   blink_cnt_r, blink_cnt_nxt;
  logic                        blink_ph_r, blink_ph_nxt;
  logic [cts_pkg::LED_W-1:0]   led_drive_r, led_drive_nxt;

  // tick datapath
  logic                        clk_end, cnt_act, cnt_end, cnt_zero, dn_zero;
  logic                        alert_a, alert_b, blink_end;
  logic                        cs_wrap, cm_wrap;
  logic [cts_pkg::CLK_H_W-1:0] ci_hour;
  logic [cts_pkg::MS_W-1:0]    ci_min, ci_sec;
  logic                        us_wrap, um_wrap;
  logic [cts_pkg::CNT_H_W-1:0] up_hour, dn_hour;
  logic [cts_pkg::MS_W-1:0]    up_min, up_sec, dn_min, dn_sec;
  logic [cts_pkg::LPOS_W-1:0]  led_a, led_b;

  // handshake
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign out_ch.valid = out_vld_r;

  assign out_ch.led_pattern  = led_drive_r;
  assign out_ch.alert        = alert_r;
  assign out_ch.clock_hour   = clk_hour_r;
  assign out_ch.clock_minute = clk_min_r;
  assign out_ch.clock_second = clk_sec_r;
  assign out_ch.count_hour   = cnt_hour_r;
  assign out_ch.count_minute = cnt_min_r;
  assign out_ch.count_second = cnt_sec_r;

  // APB
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[cts_pkg::CFG_AW-1:2];

  always_comb begin
    unique case (cfg_idx)
      cts_pkg::REG_MODE:  cfg_prdata = {{(cts_pkg::CFG_DW-cts_pkg::MODE_W){1'b0}}, mode_r};
      cts_pkg::REG_TPS:   cfg_prdata = {{(cts_pkg::CFG_DW-cts_pkg::TPS_W){1'b0}}, tps_r};
      cts_pkg::REG_BLINK: cfg_prdata = {{(cts_pkg::CFG_DW-cts_pkg::BLK_W){1'b0}}, blink_ticks_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // clock +1 s
  always_comb begin
    cs_wrap = (clk_sec_r == cts_pkg::MS_MAX);
    cm_wrap = cs_wrap && (clk_min_r == cts_pkg::MS_MAX);
    ci_sec  = cs_wrap ? '0 : clk_sec_r + 6'd1;
    ci_min  = cm_wrap ? '0 : (cs_wrap ? clk_min_r + 6'd1 : clk_min_r);
    ci_hour = clk_hour_r;
    if (cm_wrap) begin
      ci_hour = (clk_hour_r == cts_pkg::CLK_HOUR_MAX) ? '0 : clk_hour_r + 5'd1;
    end
  end

  // counter up / down
  always_comb begin
    us_wrap = (cnt_sec_r == cts_pkg::MS_MAX);
    um_wrap = us_wrap && (cnt_min_r == cts_pkg::MS_MAX);
    up_sec  = us_wrap ? '0 : cnt_sec_r + 6'd1;
    up_min  = um_wrap ? '0 : (us_wrap ? cnt_min_r + 6'd1 : cnt_min_r);
    up_hour = cnt_hour_r;
    if (um_wrap) begin
      up_hour = (cnt_hour_r == cts_pkg::CNT_HOUR_MAX) ? '0 : cnt_hour_r + 7'd1;
    end
    dn_sec  = cnt_sec_r - 6'd1;
    dn_min  = cnt_min_r;
    dn_hour = cnt_hour_r;
    if (cnt_sec_r == '0) begin
      dn_sec = cts_pkg::MS_MAX;
      if (cnt_min_r == '0) begin
        dn_min = cts_pkg::MS_MAX;
        if (cnt_hour_r != '0) dn_hour = cnt_hour_r - 7'd1;
      end else begin
        dn_min = cnt_min_r - 6'd1;
      end
    end
    cnt_zero = (cnt_hour_r == '0) && (cnt_min_r == '0) && (cnt_sec_r == '0);
    dn_zero  = (dn_hour == '0) && (dn_min == '0) && (dn_sec == '0);
  end

  // next state
  always_comb begin
    clk_run_nxt   = clk_run_r;
    clk_tick_nxt  = clk_tick_r;
    clk_hour_nxt  = clk_hour_r;
    clk_min_nxt   = clk_min_r;
    clk_sec_nxt   = clk_sec_r;
    cnt_tick_nxt  = cnt_tick_r;
    cnt_hour_nxt  = cnt_hour_r;
    cnt_min_nxt   = cnt_min_r;
    cnt_sec_nxt   = cnt_sec_r;
    led_pos_nxt   = led_pos_r;
    alert_nxt     = alert_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_ph_nxt  = blink_ph_r;
    led_drive_nxt = led_drive_r;
    mode_nxt      = mode_r;

    clk_end   = clk_run_r &&
                (({1'b0, clk_tick_r} + 13'd1) >= {1'b0, tps_r});
    alert_a   = alert_r || (clk_end && (mode_r == cts_pkg::MODE_TIMER) && cnt_zero);
    cnt_act   = (mode_r == cts_pkg::MODE_STOPWATCH) ||
                ((mode_r == cts_pkg::MODE_TIMER) && !alert_a);
    cnt_end   = cnt_act && (({1'b0, cnt_tick_r} + 13'd1) >= {1'b0, tps_r});
    alert_b   = alert_a || (cnt_end && (mode_r == cts_pkg::MODE_TIMER) && dn_zero);
    led_a     = led_pos_r + {2'b00, (clk_end && (mode_r == cts_pkg::MODE_CLOCK))};
    led_b     = led_a;
    if (cnt_end) begin
      led_b = (mode_r == cts_pkg::MODE_STOPWATCH) ? led_a + 3'd1 : led_a - 3'd1;
    end
    blink_end = ({1'b0, blink_cnt_r} + 10'd1) >= {1'b0, blink_ticks_r};

    unique case (in_op_r)
      cts_pkg::OP_TICK: begin
        if (clk_run_r) begin
          if (clk_end) begin
            clk_tick_nxt = '0;
            clk_hour_nxt = ci_hour;
            clk_min_nxt  = ci_min;
            clk_sec_nxt  = ci_sec;
          end else begin
            clk_tick_nxt = clk_tick_r + 12'd1;
          end
        end
        if (cnt_act) begin
          if (cnt_end) begin
            cnt_tick_nxt = '0;
            if (mode_r == cts_pkg::MODE_STOPWATCH) begin
              cnt_hour_nxt = up_hour;
              cnt_min_nxt  = up_min;
              cnt_sec_nxt  = up_sec;
            end else begin
              cnt_hour_nxt = dn_hour;
              cnt_min_nxt  = dn_min;
              cnt_sec_nxt  = dn_sec;
            end
          end else begin
            cnt_tick_nxt = cnt_tick_r + 12'd1;
          end
        end
        led_pos_nxt = led_b;
        alert_nxt   = alert_b;
        if (!alert_b) begin
          led_drive_nxt = 8'd1 << led_b;
        end else if (blink_end) begin
          blink_cnt_nxt = '0;
          blink_ph_nxt  = !blink_ph_r;
          led_drive_nxt = blink_ph_r ? '0 : cts_pkg::LED_ALL_ON;
        end else begin
          blink_cnt_nxt = blink_cnt_r + 9'd1;
        end
      end
      cts_pkg::OP_LOAD_CLK: begin
        clk_hour_nxt = (in_hour_r > {2'b00, cts_pkg::CLK_HOUR_MAX}) ?
                       cts_pkg::CLK_HOUR_MAX : in_hour_r[cts_pkg::CLK_H_W-1:0];
        clk_min_nxt  = (in_min_r > {1'b0, cts_pkg::MS_MAX}) ?
                       cts_pkg::MS_MAX : in_min_r[cts_pkg::MS_W-1:0];
        clk_sec_nxt  = (in_sec_r > {1'b0, cts_pkg::MS_MAX}) ?
                       cts_pkg::MS_MAX : in_sec_r[cts_pkg::MS_W-1:0];
        clk_run_nxt  = 1'b1;
      end
      cts_pkg::OP_LOAD_CNT: begin
        cnt_hour_nxt = (in_hour_r > cts_pkg::CNT_HOUR_MAX) ? cts_pkg::CNT_HOUR_MAX : in_hour_r;
        cnt_min_nxt  = (in_min_r > {1'b0, cts_pkg::MS_MAX}) ?
                       cts_pkg::MS_MAX : in_min_r[cts_pkg::MS_W-1:0];
        cnt_sec_nxt  = (in_sec_r > {1'b0, cts_pkg::MS_MAX}) ?
                       cts_pkg::MS_MAX : in_sec_r[cts_pkg::MS_W-1:0];
      end
      cts_pkg::OP_CLEAR_CNT: begin
        cnt_tick_nxt  = '0;
        blink_cnt_nxt = '0;
        cnt_hour_nxt  = '0;
        cnt_min_nxt   = '0;
        cnt_sec_nxt   = '0;
      end
      cts_pkg::OP_MENU_RST: begin
        mode_nxt      = cts_pkg::MODE_NONE;
        cnt_hour_nxt  = '0;
        cnt_min_nxt   = '0;
        cnt_sec_nxt   = '0;
        cnt_tick_nxt  = '0;
        blink_cnt_nxt = '0;
        led_pos_nxt   = '0;
        alert_nxt     = 1'b0;
        blink_ph_nxt  = 1'b0;
        led_drive_nxt = '0;
      end
      cts_pkg::OP_CLK_RST: begin
        clk_tick_nxt = '0;
        clk_run_nxt  = 1'b0;
        clk_hour_nxt = '0;
        clk_min_nxt  = '0;
        clk_sec_nxt  = '0;
      end
      default: ;
    endcase
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r   <= in_ch.op;
      in_hour_r <= in_ch.set_hour;
      in_min_r  <= in_ch.set_minute;
      in_sec_r  <= in_ch.set_second;
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      mode_r        <= cts_pkg::MODE_NONE;
      tps_r         <= cts_pkg::TPS_RST;
      blink_ticks_r <= cts_pkg::BLINK_RST;
      clk_run_r     <= 1'b0;
      clk_tick_r    <= '0;
      clk_hour_r    <= '0;
      clk_min_r     <= '0;
      clk_sec_r     <= '0;
      cnt_tick_r    <= '0;
      cnt_hour_r    <= '0;
      cnt_min_r     <= '0;
      cnt_sec_r     <= '0;
      led_pos_r     <= '0;
      alert_r       <= 1'b0;
      blink_cnt_r   <= '0;
      blink_ph_r    <= 1'b0;
      led_drive_r   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx)
          cts_pkg::REG_MODE:  mode_r        <= cfg_pwdata[cts_pkg::MODE_W-1:0];
          cts_pkg::REG_TPS:   tps_r         <= cfg_pwdata[cts_pkg::TPS_W-1:0];
          cts_pkg::REG_BLINK: blink_ticks_r <= cfg_pwdata[cts_pkg::BLK_W-1:0];
          default: ;
        endcase
      end else if (adv) begin
        mode_r <= mode_nxt;
      end

      if (adv) begin
        clk_run_r   <= clk_run_nxt;
        clk_tick_r  <= clk_tick_nxt;
        clk_hour_r  <= clk_hour_nxt;
        clk_min_r   <= clk_min_nxt;
        clk_sec_r   <= clk_sec_nxt;
        cnt_tick_r  <= cnt_tick_nxt;
        cnt_hour_r  <= cnt_hour_nxt;
        cnt_min_r   <= cnt_min_nxt;
        cnt_sec_r   <= cnt_sec_nxt;
        led_pos_r   <= led_pos_nxt;
        alert_r     <= alert_nxt;
        blink_cnt_r <= blink_cnt_nxt;
        blink_ph_r  <= blink_ph_nxt;
        led_drive_r <= led_drive_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_led_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    !alert_r |-> $onehot0(led_drive_r))
    else $error("LED drive not one-hot without alert");

  a_clk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (clk_sec_r <= cts_pkg::MS_MAX) && (clk_min_r <= cts_pkg::MS_MAX) &&
    (clk_hour_r <= cts_pkg::CLK_HOUR_MAX))
    else $error("clock value out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_sec_r <= cts_pkg::MS_MAX) && (cnt_min_r <= cts_pkg::MS_MAX) &&
    (cnt_hour_r <= cts_pkg::CNT_HOUR_MAX))
    else $error("counter value out of range");

  a_alert_timer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(alert_r) |-> ($past(mode_r) == cts_pkg::MODE_TIMER))
    else $error("alert raised outside timer mode");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(clk_sec_r) && $stable(cnt_sec_r) && $stable(led_drive_r)))
    else $error("state moved without a request");
`endif

endmodule
